### rtl/core/assert_macros.svh
// Assertion macros used by the output queue of the sound generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NEVER(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/tvsn_pkg.sv
// Package with register codes, control types and constant tables of the sound generator.
package tvsn_pkg;

    typedef enum logic [2:0] {
        REG_FREQ1_LO = 3'd0,
        REG_FREQ2_LO = 3'd1,
        REG_FREQ2_HI = 3'd2,
        REG_CONTROL  = 3'd3,
        REG_FREQ1_HI = 3'd4
    } t_reg_index;

    typedef struct packed {
        logic advance;
        logic load;
    } t_osc_ctrl;

    typedef logic [63:0][14:0] t_level_table;

    localparam logic        ACT_WRITE       = 1'b0;
    localparam logic        ACT_TICK        = 1'b1;
    localparam logic [9:0]  FREQ_FORCE_HIGH = 10'h3FE;
    localparam logic [7:0]  NOISE_LAST      = 8'd254;
    localparam logic [13:0] STEP_RESET      = 14'd40;

    function automatic logic [255:0] build_noise();
        logic [255:0] rom;
        logic [7:0]   sr;
        logic         fb;
        rom = '0;
        sr  = 8'hFF;
        for (int i = 0; i < 256; i++) begin
            fb     = sr[7] ^ sr[5] ^ sr[4] ^ sr[1];
            sr     = {sr[6:0], fb};
            rom[i] = sr[0];
        end
        return rom;
    endfunction

    function automatic t_level_table build_levels();
        t_level_table rom;
        int           vol;
        int           extra;
        int           lvl;
        logic         both;
        rom = '0;
        for (int i = 0; i < 64; i++) begin
            both  = ((i & 'h30) == 'h30);
            vol   = ((i & 'h0F) < 9) ? (i & 'h0F) : 8;
            extra = (both && vol > 1) ? vol * vol * 54 - 173 * vol + 162 : 0;
            lvl   = 0;
            if (vol != 0 && (i & 'h30) != 0) begin
                lvl = (extra + 586 + (vol - 1) * 1024) * (both ? 2 : 1);
            end
            rom[i] = lvl[14:0];
        end
        return rom;
    endfunction

    localparam logic [255:0] NOISE_ROM = build_noise();
    localparam t_level_table LEVEL_ROM = build_levels();

endpackage

### rtl/core/tvsn_osc.sv
// Phase accumulator of one voice with wrap detection and direct-mode load.
module tvsn_osc
    import tvsn_pkg::*;
#(
    parameter int FRACTION_BITS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_osc_ctrl                 i_ctrl,
    input  logic [13:0]               i_step,
    input  logic [FRACTION_BITS+9:0]  i_reload,
    output logic                      o_wrap
);

    localparam int PW = 12 + FRACTION_BITS;
    localparam int SW = PW + 14;
    localparam logic [PW-1:0] PERIOD = {2'b01, {(PW - 2){1'b0}}};

    logic [PW-1:0] r_phase;
    logic [PW-1:0] n_phase;
    logic [SW-1:0] w_step_wide;
    logic [PW-1:0] w_step;
    logic [PW-1:0] w_sum;
    logic [PW-1:0] w_reload;
    logic          w_ge;

    assign w_step_wide = SW'(i_step);
    assign w_step      = w_step_wide[PW-1:0];
    assign w_sum       = r_phase + w_step;
    assign w_reload    = {2'b00, i_reload};
    assign w_ge        = (w_sum >= PERIOD);
    assign o_wrap      = i_ctrl.advance && w_ge;

    always_comb begin
        n_phase = r_phase;
        if (i_ctrl.load) begin
            n_phase = w_reload;
        end else if (i_ctrl.advance) begin
            n_phase = w_ge ? (w_sum - PERIOD + w_reload) : w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

### rtl/core/tvsn_core.sv
// Sound register file, voice flip-flops, noise position and sample level selection.
module tvsn_core
    import tvsn_pkg::*;
#(
    parameter int FRACTION_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [13:0] i_cfg_wdata,
    input  logic        i_accept,
    input  logic        i_action,
    input  logic [2:0]  i_reg_index,
    input  logic [7:0]  i_write_value,
    output logic        o_push,
    output logic [14:0] o_sample
);

    localparam int RW = 10 + FRACTION_BITS;
    localparam logic [RW-1:0] STOP = RW'(10'h3FF) << FRACTION_BITS;

    function automatic logic [RW-1:0] reload_of(input logic [9:0] f);
        logic [9:0] inc;
        inc = f + 10'd1;
        return RW'(inc) << FRACTION_BITS;
    endfunction

    logic [13:0]   r_step;
    logic [9:0]    r_freq_one, n_freq_one;
    logic [9:0]    r_freq_two, n_freq_two;
    logic [RW-1:0] r_reload_one, n_reload_one;
    logic [RW-1:0] r_reload_two, n_reload_two;
    logic [1:0]    r_toggles, n_toggles;
    logic [3:0]    r_volume, n_volume;
    logic [1:0]    r_enables, n_enables;
    logic          r_noise_on, n_noise_on;
    logic          r_direct, n_direct;
    logic [14:0]   r_direct_level, n_direct_level;
    logic [5:0]    r_level_one, n_level_one;
    logic [5:0]    r_level_two, n_level_two;
    logic [7:0]    r_noise_pos, n_noise_pos;

    logic          w_write;
    logic          w_tick;
    logic          w_wrap_one;
    logic          w_wrap_two;
    t_osc_ctrl     w_ctrl_one;
    t_osc_ctrl     w_ctrl_two;
    t_reg_index    w_index;

    assign w_write = i_accept && (i_action == ACT_WRITE);
    assign w_tick  = i_accept && (i_action == ACT_TICK);
    assign w_index = t_reg_index'(i_reg_index);

    always_comb begin
        w_ctrl_one.load    = w_write && (w_index == REG_CONTROL) && i_write_value[7];
        w_ctrl_two.load    = w_ctrl_one.load;
        w_ctrl_one.advance = w_tick && !r_direct && (r_reload_one != STOP);
        w_ctrl_two.advance = w_tick && !r_direct && (r_reload_two != STOP);
    end

    tvsn_osc #(.FRACTION_BITS(FRACTION_BITS)) u_osc_one (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl_one),
        .i_step   (r_step),
        .i_reload (r_reload_one),
        .o_wrap   (w_wrap_one)
    );

    tvsn_osc #(.FRACTION_BITS(FRACTION_BITS)) u_osc_two (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl_two),
        .i_step   (r_step),
        .i_reload (r_reload_two),
        .o_wrap   (w_wrap_two)
    );

    always_comb begin
        n_freq_one     = r_freq_one;
        n_freq_two     = r_freq_two;
        n_reload_one   = r_reload_one;
        n_reload_two   = r_reload_two;
        n_toggles      = r_toggles;
        n_volume       = r_volume;
        n_enables      = r_enables;
        n_noise_on     = r_noise_on;
        n_direct       = r_direct;
        n_direct_level = r_direct_level;
        n_level_one    = r_level_one;
        n_level_two    = r_level_two;
        n_noise_pos    = r_noise_pos;

        if (w_write) begin
            unique case (w_index)
                REG_FREQ1_LO: begin
                    n_freq_one = {r_freq_one[9:8], i_write_value};
                end
                REG_FREQ1_HI: begin
                    n_freq_one = {i_write_value[1:0], r_freq_one[7:0]};
                end
                REG_FREQ2_LO: begin
                    n_freq_two = {r_freq_two[9:8], i_write_value};
                end
                REG_FREQ2_HI: begin
                    n_freq_two = {i_write_value[1:0], r_freq_two[7:0]};
                end
                REG_CONTROL: begin
                    n_direct = i_write_value[7];
                    if (i_write_value[7]) begin
                        n_toggles      = 2'b11;
                        n_noise_pos    = '0;
                        n_direct_level = LEVEL_ROM[i_write_value[5:0]];
                    end
                    n_volume    = i_write_value[3:0];
                    n_enables   = i_write_value[5:4];
                    n_noise_on  = i_write_value[6] && !i_write_value[5];
                    n_level_one = {1'b0, n_toggles[0] & n_enables[0], n_volume};
                    n_level_two = {(n_toggles[1] & n_enables[1])
                                   | (n_noise_on & NOISE_ROM[n_noise_pos]),
                                   1'b0, n_volume};
                end
                default: begin
                end
            endcase

            if (w_index == REG_FREQ1_LO || w_index == REG_FREQ1_HI) begin
                n_reload_one = reload_of(n_freq_one);
                if (n_freq_one == FREQ_FORCE_HIGH) begin
                    n_toggles[0] = 1'b1;
                    n_level_one  = {1'b0, r_enables[0], r_volume};
                end
            end
            if (w_index == REG_FREQ2_LO || w_index == REG_FREQ2_HI) begin
                n_reload_two = reload_of(n_freq_two);
                if (n_freq_two == FREQ_FORCE_HIGH) begin
                    n_toggles[1] = 1'b1;
                    n_level_two  = {r_enables[1], r_noise_on, r_volume};
                end
            end
        end

        if (w_wrap_one) begin
            n_toggles[0] = ~r_toggles[0];
            n_level_one  = {1'b0, n_toggles[0] & r_enables[0], r_volume};
        end
        if (w_wrap_two) begin
            n_toggles[1] = ~r_toggles[1];
            n_level_two  = {(n_toggles[1] & r_enables[1])
                            | (r_noise_on & NOISE_ROM[r_noise_pos]),
                            1'b0, r_volume};
            n_noise_pos  = (r_noise_pos == NOISE_LAST) ? 8'd0 : r_noise_pos + 8'd1;
        end
    end

    assign o_push   = w_tick;
    assign o_sample = r_direct ? r_direct_level : LEVEL_ROM[n_level_one | n_level_two];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step         <= STEP_RESET;
            r_freq_one     <= '0;
            r_freq_two     <= '0;
            r_reload_one   <= '0;
            r_reload_two   <= '0;
            r_toggles      <= '0;
            r_volume       <= '0;
            r_enables      <= '0;
            r_noise_on     <= 1'b0;
            r_direct       <= 1'b0;
            r_direct_level <= '0;
            r_level_one    <= '0;
            r_level_two    <= '0;
            r_noise_pos    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            r_freq_one     <= n_freq_one;
            r_freq_two     <= n_freq_two;
            r_reload_one   <= n_reload_one;
            r_reload_two   <= n_reload_two;
            r_toggles      <= n_toggles;
            r_volume       <= n_volume;
            r_enables      <= n_enables;
            r_noise_on     <= n_noise_on;
            r_direct       <= n_direct;
            r_direct_level <= n_direct_level;
            r_level_one    <= n_level_one;
            r_level_two    <= n_level_two;
            r_noise_pos    <= n_noise_pos;
        end
    end

endmodule

### rtl/core/tvsn_outq.sv
// Output register with a skid stage that holds one sample while the consumer stalls.
`include "assert_macros.svh"
module tvsn_outq
    import tvsn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [14:0] i_sample,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [14:0] o_sample,
    output logic        o_full
);

    logic        r_out_valid;
    logic [14:0] r_out_sample;
    logic        r_skid_valid;
    logic [14:0] r_skid_sample;
    logic        w_pop;

    assign w_pop    = r_out_valid && !i_stall;
    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;
    assign o_full   = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (r_skid_valid) begin
                if (w_pop) begin
                    r_out_sample <= r_skid_sample;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (!r_out_valid || w_pop) begin
                    r_out_sample <= i_sample;
                    r_out_valid  <= 1'b1;
                end else begin
                    r_skid_sample <= i_sample;
                    r_skid_valid  <= 1'b1;
                end
            end else if (w_pop) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    `ASSERT_IMPLIES(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, r_skid_valid && i_push)
    `ASSERT_NEXT(a_held_stays, i_clk, i_rst_n, r_out_valid && i_stall, r_out_valid)
    `ASSERT_NEXT(a_skid_fills, i_clk, i_rst_n, r_out_valid && i_stall && i_push, r_skid_valid)

endmodule

### rtl/core/two_voice_square_noise_sound.sv
// Two-voice square and noise sound generator, one register write or sample tick per item.
// A tick's sample is registered at the output, or in the skid stage if the output is held.
// Throughput: one item per cycle while o_stall is low; the output register and a one-deep skid
// stage absorb stalls. o_stall rises only while two samples wait and drops when one is taken.
// Reset (synchronous, active low) clears all voice state and sets the phase step to 40.
module two_voice_square_noise_sound
    import tvsn_pkg::*;
#(
    parameter int FRACTION_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [13:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [2:0]  i_reg_index,
    input  logic [7:0]  i_write_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_sample
);

    logic        w_full;
    logic        w_accept;
    logic        w_push;
    logic [14:0] w_sample;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    tvsn_core #(.FRACTION_BITS(FRACTION_BITS)) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (w_accept),
        .i_action      (i_action),
        .i_reg_index   (i_reg_index),
        .i_write_value (i_write_value),
        .o_push        (w_push),
        .o_sample      (w_sample)
    );

    tvsn_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_sample (w_sample),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_sample (o_sample),
        .o_full   (w_full)
    );

endmodule
